/* hdl/dtt_pkg.sv */
// shared types and codes for the deadline timer table
// no dependencies
package dtt_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int TimeW = 48;
	localparam int PerW  = 32;

	localparam logic [2:0] REQ_ADD     = 3'd0;
	localparam logic [2:0] REQ_CANCEL  = 3'd1;
	localparam logic [2:0] REQ_REFRESH = 3'd2;
	localparam logic [2:0] REQ_RESET   = 3'd3;
	localparam logic [2:0] REQ_SWEEP   = 3'd4;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic [31:0] WINDOW_RESET = 32'd3600000;

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_ADJ, S_FRONT, S_ARM, S_PEND, S_SEL,
		S_APPLY, S_MIN, S_FIN, S_EMIT
	} state_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_t;

endpackage

/* hdl/dtt_alu.sv */
// shared 48-bit adder and magnitude comparator for the timer table sequencer
// depends on dtt_pkg
module dtt_alu import dtt_pkg::*; (
	input  logic [TimeW-1:0] add_a,
	input  logic [TimeW-1:0] add_b,
	input  logic [TimeW-1:0] cmp_a,
	input  logic [TimeW-1:0] cmp_b,
	output logic [TimeW-1:0] sum,
	output cmp_t             cmp
);
	assign sum    = add_a + add_b;
	assign cmp.lt = cmp_a < cmp_b;
	assign cmp.eq = cmp_a == cmp_b;
endmodule

/* hdl/deadline_timer_table.sv */
// Timer table of NUM_TIMERS slots driven by one request at a time. A request is taken
// only while the block is idle; it then runs a small sequencer that walks the slots one
// per cycle through a single shared adder and comparator. An add or a reset that re-arms
// its timer walks the slots to see if it becomes the front deadline, arms it, then walks
// them for the earliest deadline; cancel, refresh, a full add and a refused or unchanged
// reset make only that walk. A sweep marks due timers, picks them out one walk each in
// deadline order, applies them and makes that walk too. Time sums wrap modulo 2^48.
// depends on dtt_pkg and dtt_alu
module deadline_timer_table import dtt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       req_type,
	input  logic [3:0]       timer_id,
	input  logic [31:0]      period_ms,
	input  logic             recurring,
	input  logic             restart_now,
	input  logic [47:0]      now_ms,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       status,
	output logic [3:0]       timer_handle,
	output logic             expired,
	output logic [47:0]      wait_ms,
	output logic             front_notice,
	output logic             any_active,
	output logic             last
);
	localparam int IW = $clog2(NUM_TIMERS);
	localparam int CW = $clog2(NUM_TIMERS + 1);
	localparam logic [CW-1:0] CNT_LAST = CW'(NUM_TIMERS - 1);

	state_t state_q, state_d;

	logic [31:0]       window_q;
	logic [TimeW-1:0]  deadline_q [NUM_TIMERS];
	logic [PerW-1:0]   period_q   [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] active_q, recur_q, pend_q, fired_q;
	logic [TimeW-1:0]  prev_q;
	logic              notified_q;

	logic [2:0]        req_q;
	logic [3:0]        id_q;
	logic [PerW-1:0]   ms_q;
	logic              rec_q, fn_q;
	logic [TimeW-1:0]  now_q;

	logic [IW-1:0]     slot_q, best_idx_q;
	logic [TimeW-1:0]  d_q, best_dl_q, min_q, wait_q;
	logic [CW-1:0]     cnt_q, nord_q, emit_q;
	logic              front_q, roll_q, got_q, any_q, nt_q;
	logic [1:0]        status_q;
	logic [IW-1:0]     order_q [NUM_TIMERS];

	logic              ov_q;
	logic [1:0]        o_status_q;
	logic [3:0]        o_handle_q;
	logic              o_exp_q, o_nt_q, o_any_q, o_last_q;
	logic [47:0]       o_wait_q;

	// shared read port and arithmetic
	logic [IW-1:0]     rd_idx;
	logic [TimeW-1:0]  rd_dl;
	logic [PerW-1:0]   rd_per;
	logic [TimeW-1:0]  add_a, add_b, cmp_a, cmp_b, sum;
	cmp_t              cmp;

	logic              valid_id, cnt_last, full, out_free;
	logic [IW-1:0]     id_slot, free_idx;
	logic              sel_take, sel_got;
	logic [IW-1:0]     sel_idx;
	logic [TimeW-1:0]  sel_dl;
	logic [CW-1:0]     n_res;

	assign valid_id = 32'(id_q) < 32'(NUM_TIMERS);
	assign id_slot  = IW'(id_q);
	assign cnt_last = cnt_q == CNT_LAST;
	assign full     = &active_q;
	assign out_free = !ov_q || !out_stall;
	assign rd_idx   = (state_q == S_PREP) ? id_slot : cnt_q[IW-1:0];
	assign rd_dl    = deadline_q[rd_idx];
	assign rd_per   = period_q[rd_idx];

	always_comb begin
		free_idx = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!active_q[i]) free_idx = IW'(i);
		end
	end

	always_comb begin
		add_a = d_q;
		add_b = TimeW'(ms_q);
		cmp_a = rd_dl;
		cmp_b = d_q;
		unique case (state_q)
			S_PREP: begin
				add_a = now_q;
				add_b = TimeW'(rd_per);
			end
			S_APPLY: begin
				add_a = now_q;
				add_b = TimeW'(rd_per);
			end
			S_PEND: cmp_b = now_q;
			S_SEL:  cmp_b = best_dl_q;
			S_MIN:  cmp_b = min_q;
			S_FIN: begin
				cmp_a = now_q;
				cmp_b = min_q;
			end
			default: ;
		endcase
	end

	dtt_alu u_alu (
		.add_a(add_a), .add_b(add_b), .cmp_a(cmp_a), .cmp_b(cmp_b),
		.sum(sum), .cmp(cmp)
	);

	assign sel_take = pend_q[cnt_q[IW-1:0]] && (!got_q || cmp.lt);
	assign sel_got  = got_q || sel_take;
	assign sel_idx  = sel_take ? cnt_q[IW-1:0] : best_idx_q;
	assign sel_dl   = sel_take ? rd_dl : best_dl_q;
	assign n_res    = (req_q == REQ_SWEEP && nord_q != '0) ? nord_q : CW'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_d = S_PREP;
			S_PREP: begin
				unique case (req_q)
					REQ_ADD:   state_d = full ? S_MIN : S_ADJ;
					REQ_RESET: state_d = (valid_id && !(ms_q == rd_per && !fn_q)
						&& active_q[id_slot]) ? S_ADJ : S_MIN;
					REQ_SWEEP: state_d = S_PEND;
					default:   state_d = S_MIN;
				endcase
			end
			S_ADJ:   state_d = S_FRONT;
			S_FRONT: if (cnt_last) state_d = S_ARM;
			S_ARM:   state_d = S_MIN;
			S_PEND:  if (cnt_last) state_d = S_SEL;
			S_SEL:   if (cnt_last && !sel_got) state_d = S_APPLY;
			S_APPLY: if (cnt_last) state_d = S_MIN;
			S_MIN:   if (cnt_last) state_d = S_FIN;
			S_FIN:   state_d = S_EMIT;
			S_EMIT:  if (out_free && emit_q == n_res - CW'(1)) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= WINDOW_RESET;
			active_q   <= '0;
			recur_q    <= '0;
			prev_q     <= '0;
			notified_q <= 1'b0;
			ov_q       <= 1'b0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				deadline_q[i] <= '0;
				period_q[i]   <= '0;
			end
		end else begin
			if (cfg_we) window_q <= cfg_wdata;
			// a beat is held until taken, a new one loads only in the emit state
			ov_q <= (state_q == S_EMIT && out_free) || (ov_q && out_stall);
			unique case (state_q)
				S_PREP: begin
					unique case (req_q)
						REQ_CANCEL:  if (valid_id && active_q[id_slot]) active_q[id_slot] <= 1'b0;
						REQ_REFRESH: if (valid_id && active_q[id_slot]) deadline_q[id_slot] <= sum;
						REQ_SWEEP:   prev_q <= now_q;
						default: ;
					endcase
				end
				S_ARM: begin
					deadline_q[slot_q] <= d_q;
					active_q[slot_q]   <= 1'b1;
					period_q[slot_q]   <= ms_q;
					if (req_q == REQ_ADD) recur_q[slot_q] <= rec_q;
					if (front_q && !notified_q) notified_q <= 1'b1;
				end
				S_APPLY: begin
					notified_q <= 1'b0;
					if (fired_q[cnt_q[IW-1:0]]) begin
						if (recur_q[cnt_q[IW-1:0]]) deadline_q[cnt_q[IW-1:0]] <= sum;
						else active_q[cnt_q[IW-1:0]] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q <= req_type;
				id_q  <= timer_id;
				ms_q  <= period_ms;
				rec_q <= recurring;
				fn_q  <= restart_now;
				now_q <= now_ms;
				nt_q  <= 1'b0;
				nord_q <= '0;
				fired_q <= '0;
				slot_q <= '0;
			end
			S_PREP: begin
				cnt_q   <= '0;
				front_q <= 1'b1;
				any_q   <= 1'b0;
				unique case (req_q) inside
					REQ_ADD: begin
						status_q <= full ? ST_FULL : ST_DONE;
						slot_q   <= free_idx;
						d_q      <= now_q;
					end
					REQ_CANCEL, REQ_REFRESH:
						status_q <= (valid_id && active_q[id_slot]) ? ST_DONE : ST_REFUSED;
					REQ_RESET: begin
						slot_q <= id_slot;
						d_q    <= fn_q ? now_q : rd_dl - TimeW'(rd_per);
						status_q <= (valid_id && ((ms_q == rd_per && !fn_q)
							|| active_q[id_slot])) ? ST_DONE : ST_REFUSED;
					end
					REQ_SWEEP: begin
						status_q <= ST_DONE;
						roll_q <= (prev_q >= TimeW'(window_q))
							&& (now_q < prev_q - TimeW'(window_q));
					end
					default: status_q <= ST_REFUSED;
				endcase
			end
			S_ADJ: d_q <= sum;
			S_FRONT: begin
				cnt_q <= cnt_last ? '0 : cnt_q + CW'(1);
				if (cnt_q[IW-1:0] != slot_q && active_q[cnt_q[IW-1:0]] && (cmp.lt || cmp.eq))
					front_q <= 1'b0;
			end
			S_ARM: begin
				nt_q  <= front_q && !notified_q;
				cnt_q <= '0;
			end
			S_PEND: begin
				pend_q[cnt_q[IW-1:0]] <= active_q[cnt_q[IW-1:0]]
					&& (roll_q || cmp.lt || cmp.eq);
				cnt_q <= cnt_last ? '0 : cnt_q + CW'(1);
				got_q <= 1'b0;
			end
			S_SEL: begin
				got_q      <= cnt_last ? 1'b0 : sel_got;
				best_idx_q <= sel_idx;
				best_dl_q  <= sel_dl;
				cnt_q      <= cnt_last ? '0 : cnt_q + CW'(1);
				if (cnt_last && sel_got) begin
					order_q[nord_q[IW-1:0]] <= sel_idx;
					nord_q           <= nord_q + CW'(1);
					pend_q[sel_idx]  <= 1'b0;
					fired_q[sel_idx] <= 1'b1;
				end
			end
			S_APPLY: begin
				cnt_q <= cnt_last ? '0 : cnt_q + CW'(1);
				any_q <= 1'b0;
			end
			S_MIN: begin
				cnt_q <= cnt_q + CW'(1);
				if (active_q[cnt_q[IW-1:0]] && (!any_q || cmp.lt)) begin
					any_q <= 1'b1;
					min_q <= rd_dl;
				end
			end
			S_FIN: begin
				emit_q <= '0;
				if (!any_q) wait_q <= '1;
				else if (!cmp.lt) wait_q <= '0;
				else wait_q <= min_q - now_q;
			end
			S_EMIT: begin
				if (out_free) begin
					emit_q     <= emit_q + CW'(1);
					o_status_q <= status_q;
					o_wait_q   <= wait_q;
					o_any_q    <= any_q;
					o_nt_q     <= nt_q;
					o_last_q   <= emit_q == n_res - CW'(1);
					o_exp_q    <= req_q == REQ_SWEEP && nord_q != '0;
					if (req_q == REQ_SWEEP && nord_q != '0)
						o_handle_q <= 4'(order_q[emit_q[IW-1:0]]);
					else if (req_q == REQ_ADD && status_q == ST_DONE)
						o_handle_q <= 4'(slot_q);
					else
						o_handle_q <= '0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = ov_q;
	assign status       = o_status_q;
	assign timer_handle = o_handle_q;
	assign expired      = o_exp_q;
	assign wait_ms      = o_wait_q;
	assign front_notice = o_nt_q;
	assign any_active   = o_any_q;
	assign last         = o_last_q;

endmodule
